>>> src/hvt_pkg.sv
// Shared widths, register map and payload types of the homogeneous vector transform.
package hvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 2 * DATA_W;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int ADDR_W    = IDX_W + 3;
    localparam int DIM       = 4;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COL0_LO = 3'd0;
    localparam logic [IDX_W-1:0] REG_COL0_HI = 3'd1;
    localparam logic [IDX_W-1:0] REG_COL1_LO = 3'd2;
    localparam logic [IDX_W-1:0] REG_COL1_HI = 3'd3;
    localparam logic [IDX_W-1:0] REG_COL2_LO = 3'd4;
    localparam logic [IDX_W-1:0] REG_COL2_HI = 3'd5;
    localparam logic [IDX_W-1:0] REG_COL3_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_COL3_HI = 3'd7;

    localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));

    localparam logic signed [PAIR_W-1:0] HALF_LSB = PAIR_W'(65'd1 << (FRAC_BITS - 1));

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef logic [NUM_REGS-1:0][REG_W-1:0]         regs_t;
    typedef logic [DIM*DIM-1:0][DATA_W-1:0]         mat_t;
    typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0]    prod_t;
    typedef logic [DIM-1:0][SUM_W-1:0]              sum_t;

    // Identity matrix, listed from col3_hi down to col0_lo
    localparam regs_t REGS_RESET = {
        ONE_HI,     REG_W'(0),
        ONE_LO,     REG_W'(0),
        REG_W'(0),  ONE_HI,
        REG_W'(0),  ONE_LO
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
        logic signed [DATA_W-1:0] in_w;
    } vec_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } res_t;

endpackage

>>> src/hvt_regs.sv
// APB register file holding the 4x4 transform matrix.
module hvt_regs
    import hvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output mat_t              mat
);

    regs_t            col_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= REGS_RESET;
        end
        else if (wr_en)
        begin
            col_reg[idx] <= pwdata;
        end
    end

    assign prdata = col_reg[idx];

    // Split each register into its even (low) and odd (high) entry
    always_comb
    begin
        for (int k = 0; k < NUM_REGS; k++)
        begin
            mat[2*k]   = col_reg[k][DATA_W-1:0];
            mat[2*k+1] = col_reg[k][REG_W-1:DATA_W];
        end
    end

endmodule

>>> src/hvt_mul.sv
// Stage 1: sixteen registered 32x32 signed products of matrix and vector.
module hvt_mul
    import hvt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  vec_t  vec,
    input  mat_t  mat,
    output logic  valid_reg,
    output prod_t prod_reg
);

    logic signed [DATA_W-1:0] comp [DIM];
    logic signed [DATA_W-1:0] coef;
    logic signed [PROD_W-1:0] p;
    prod_t                    prod_next;

    always_comb
    begin
        comp[0] = vec.in_x;
        comp[1] = vec.in_y;
        comp[2] = vec.in_z;
        comp[3] = vec.in_w;
    end

    // Row r, column c: m[4c+r] times component c
    always_comb
    begin
        coef      = '0;
        p         = '0;
        prod_next = '0;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                coef            = $signed(mat[DIM*c+r]);
                p               = coef * comp[c];
                prod_next[r][c] = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

>>> src/hvt_acc.sv
// Stages 2 and 3: pairwise then final sum of each row, with the rounding half added.
module hvt_acc
    import hvt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  prod_t prod,
    output logic  valid_reg,
    output sum_t  sum_reg
);

    logic                     pair_valid_reg;
    logic [DIM-1:0][PAIR_W-1:0] lo_reg, lo_next;
    logic [DIM-1:0][PAIR_W-1:0] hi_reg, hi_next;
    sum_t                     sum_next;

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            lo_next[r] = PAIR_W'($signed(prod[r][0])) + PAIR_W'($signed(prod[r][1]))
                       + HALF_LSB;
            hi_next[r] = PAIR_W'($signed(prod[r][2])) + PAIR_W'($signed(prod[r][3]));
            sum_next[r] = SUM_W'($signed(lo_reg[r])) + SUM_W'($signed(hi_reg[r]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= in_valid;
            valid_reg      <= pair_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sum_reg <= sum_next;
    end

endmodule

>>> src/hvt_sat.sv
// Stage 4: drop the fraction bits, clip to 32 bits and register the result word.
module hvt_sat
    import hvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sum_t sum,
    output logic done,
    output res_t result
);

    logic                     done_reg;
    res_t                     res_reg, res_next;
    logic signed [SUM_W-1:0]  sh;
    logic [DIM-1:0]           clip;
    logic [DIM-1:0][DATA_W-1:0] val;

    always_comb
    begin
        sh = '0;
        for (int r = 0; r < DIM; r++)
        begin
            // floor division by 2^FRAC_BITS; the half was added upstream
            sh = $signed(sum[r]) >>> FRAC_BITS;
            if (sh > SAT_MAX)
            begin
                val[r]  = SAT_MAX[DATA_W-1:0];
                clip[r] = 1'b1;
            end
            else if (sh < SAT_MIN)
            begin
                val[r]  = SAT_MIN[DATA_W-1:0];
                clip[r] = 1'b1;
            end
            else
            begin
                val[r]  = sh[DATA_W-1:0];
                clip[r] = 1'b0;
            end
        end
        res_next.out_x     = val[0];
        res_next.out_y     = val[1];
        res_next.out_z     = val[2];
        res_next.out_w     = val[3];
        res_next.saturated = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> src/homogeneous_vector_transform.sv
// Top level: 4x4 fixed-point matrix times homogeneous vector, four-stage pipeline.
//
//  channel   handshake               payload         notes
//  -------   ---------------------   -------------   ------------------------------
//  item      start (busy held low)   item (vec_t)    one word taken per start cycle
//  result    done (one-cycle strobe) result (res_t)  receiver must take it at once
//  config    APB psel/penable/pwrite paddr/pwdata    8 x 64-bit regs at 8*index
//
//  A word enters on every cycle that start is high; busy is never raised.
//  Four register stages: sixteen 32x32 multipliers, two adder stages (pair
//  sums with the rounding half, then the row total), and one shift-and-clip
//  output stage. The accepting edge loads the first stage; the word then
//  passes the pair and total registers; done rises as the output loads.
//  Reset clears the valid bits of every stage and loads the identity matrix.
//  The receiver cannot stall, so the pipeline never holds.
module homogeneous_vector_transform
    import hvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              start,
    output logic              busy,
    input  vec_t              item,
    // result channel
    output logic              done,
    output res_t              result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

    mat_t  mat;
    logic  accept;
    logic  mul_valid;
    prod_t prod;
    logic  acc_valid;
    sum_t  sum;

    // Every stage advances every cycle, so the input side is always open
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    hvt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    // Stage 1: products
    hvt_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec       (item),
        .mat       (mat),
        .valid_reg (mul_valid),
        .prod_reg  (prod)
    );

    // Stages 2 and 3: row sums plus half an LSB
    hvt_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .prod      (prod),
        .valid_reg (acc_valid),
        .sum_reg   (sum)
    );

    // Stage 4: round, clip, flag and present the result word
    hvt_sat u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc_valid),
        .sum      (sum),
        .done     (done),
        .result   (result)
    );

endmodule
